// ----- rtl/core/clle_pkg.sv -----
// Shared types, constants and helpers for the cursor linked list engine.
// No dependencies; imported by every module of the engine.
package clle_pkg;

    localparam int NODES   = 32;
    localparam int IDX_W   = $clog2(NODES);
    localparam int LINK_W  = 6;
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 5;
    localparam int LEN_W   = 6;

    localparam logic [LINK_W-1:0] NULL_LINK = 6'd63;

    localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS_SORT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_HEAD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEL_TAIL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DEL_VAL  = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STAT_W-1:0] ST_DUP    = 2'd3;

    typedef struct packed {
        logic              load;
        logic              rd_cur;
        logic              rd_link;
        logic              rd_free;
        logic              rd_head;
        logic              advance;
        logic              alloc;
        logic              ins_w1;
        logic              ins_w2;
        logic              set_after;
        logic              give;
        logic              out_load;
        logic              st_set;
        logic [STAT_W-1:0] st_code;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              cur_node;
        logic              link_node;
        logic              free_node;
        logic              steps_done;
        logic              steps_last;
        logic              val_gt;
        logic              val_eq;
        logic              out_busy;
    } t_stat;

    function automatic logic is_node(input logic [LINK_W-1:0] x);
        return x < LINK_W'(NODES);
    endfunction

    function automatic logic [LINK_W-1:0] norm_link(input logic [LINK_W-1:0] x);
        return is_node(x) ? x : NULL_LINK;
    endfunction

    function automatic logic [LINK_W-1:0] init_link(input logic [IDX_W-1:0] a);
        logic [LINK_W-1:0] nx;
        nx = LINK_W'(a) + LINK_W'(1);
        return is_node(nx) ? nx : NULL_LINK;
    endfunction

endpackage

// ----- rtl/core/clle_dp.sv -----
// Datapath of the cursor linked list engine: node value and link memories,
// list and free list pointers, walk cursor and result register. Uses clle_pkg.
module clle_dp
    import clle_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic [KIND_W-1:0]       i_kind,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_ready,
    output logic                    o_valid,
    output logic [STAT_W-1:0]       o_status,
    output logic [SLOT_W-1:0]       o_slot,
    output logic [LEN_W-1:0]        o_length,
    output logic signed [VAL_W-1:0] o_head_value,
    output logic                    o_is_empty
);

    logic [VAL_W-1:0]  r_val_mem  [NODES];
    logic [LINK_W-1:0] r_link_mem [NODES];
    logic [NODES-1:0]  r_link_vld;
    logic [VAL_W-1:0]  r_val_q;
    logic [LINK_W-1:0] r_link_q;

    logic [KIND_W-1:0] r_kind;
    logic [VAL_W-1:0]  r_value;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_prev, n_prev;
    logic [LINK_W-1:0] r_steps, n_steps;
    logic [LINK_W-1:0] r_node;
    logic [LINK_W-1:0] r_list_head, n_list_head;
    logic [LINK_W-1:0] r_free_head, n_free_head;
    logic [LEN_W-1:0]  r_count, n_count;
    logic [STAT_W-1:0] r_status, n_status;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_o_valid;

    logic              rd_en;
    logic [LINK_W-1:0] rd_ptr;
    logic              lw_en;
    logic [LINK_W-1:0] lw_ptr;
    logic [LINK_W-1:0] lw_data;
    logic [LINK_W-1:0] tgt;

    always_comb begin
        rd_ptr = r_cur;
        if (i_cmd.rd_link) begin
            rd_ptr = r_link_q;
        end else if (i_cmd.rd_free) begin
            rd_ptr = r_free_head;
        end else if (i_cmd.rd_head) begin
            rd_ptr = r_list_head;
        end
        rd_en = (i_cmd.rd_cur | i_cmd.rd_link | i_cmd.rd_free | i_cmd.rd_head)
                && is_node(rd_ptr);
    end

    always_comb begin
        tgt = (r_kind == KIND_DEL_TAIL) ? NULL_LINK : norm_link(r_link_q);
        lw_en   = 1'b0;
        lw_ptr  = r_node;
        lw_data = NULL_LINK;
        if (i_cmd.ins_w1) begin
            lw_en = 1'b1;
            case (r_kind)
                KIND_INS_HEAD: lw_data = r_list_head;
                KIND_INS_SORT: lw_data = norm_link(r_cur);
                default:       lw_data = NULL_LINK;
            endcase
        end else if (i_cmd.ins_w2) begin
            lw_en   = is_node(r_prev);
            lw_ptr  = r_prev;
            lw_data = r_node;
        end else if (i_cmd.set_after) begin
            lw_en   = is_node(r_prev);
            lw_ptr  = r_prev;
            lw_data = tgt;
        end else if (i_cmd.give) begin
            lw_en   = 1'b1;
            lw_ptr  = r_cur;
            lw_data = r_free_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_w1) begin
            r_val_mem[r_node[IDX_W-1:0]] <= r_value;
        end
        if (lw_en) begin
            r_link_mem[lw_ptr[IDX_W-1:0]] <= lw_data;
        end
        if (rd_en) begin
            r_val_q  <= r_val_mem[rd_ptr[IDX_W-1:0]];
            r_link_q <= r_link_vld[rd_ptr[IDX_W-1:0]] ?
                        r_link_mem[rd_ptr[IDX_W-1:0]] : init_link(rd_ptr[IDX_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
        end else if (lw_en) begin
            r_link_vld[lw_ptr[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_comb begin
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_steps     = r_steps;
        n_list_head = r_list_head;
        n_free_head = r_free_head;
        n_count     = r_count;
        n_status    = r_status;
        n_slot      = r_slot;
        if (i_cmd.load) begin
            n_cur    = r_list_head;
            n_prev   = NULL_LINK;
            n_steps  = '0;
            n_status = ST_DONE;
            n_slot   = '0;
        end
        if (i_cmd.advance) begin
            n_prev  = r_cur;
            n_cur   = r_link_q;
            n_steps = r_steps + LINK_W'(1);
        end
        if (i_cmd.alloc) begin
            n_free_head = r_link_q;
            n_count     = r_count + LEN_W'(1);
        end
        if (i_cmd.ins_w1) begin
            n_slot = r_node[SLOT_W-1:0];
            if (r_kind == KIND_INS_HEAD) begin
                n_list_head = r_node;
            end
        end
        if (i_cmd.ins_w2 && !is_node(r_prev)) begin
            n_list_head = r_node;
        end
        if (i_cmd.set_after && !is_node(r_prev)) begin
            n_list_head = tgt;
        end
        if (i_cmd.give) begin
            n_free_head = r_cur;
            n_count     = r_count - LEN_W'(1);
            n_slot      = r_cur[SLOT_W-1:0];
        end
        if (i_cmd.st_set) begin
            n_status = i_cmd.st_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_head <= NULL_LINK;
            r_free_head <= '0;
            r_count     <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_list_head <= n_list_head;
            r_free_head <= n_free_head;
            r_count     <= n_count;
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_slot   <= n_slot;
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        if (i_cmd.alloc) begin
            r_node <= r_free_head;
        end
        if (i_cmd.out_load) begin
            o_status     <= r_status;
            o_slot       <= r_slot;
            o_length     <= r_count;
            o_head_value <= is_node(r_list_head) ? r_val_q : '0;
            o_is_empty   <= !is_node(r_list_head);
        end
    end

    assign o_valid = r_o_valid;

    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.cur_node   = is_node(r_cur);
        o_stat.link_node  = is_node(r_link_q);
        o_stat.free_node  = is_node(r_free_head);
        o_stat.steps_done = r_steps >= LINK_W'(NODES);
        o_stat.steps_last = r_steps == LINK_W'(NODES - 1);
        o_stat.val_gt     = $signed(r_value) > $signed(r_val_q);
        o_stat.val_eq     = r_value == r_val_q;
        o_stat.out_busy   = r_o_valid && !i_ready;
    end

endmodule

// ----- rtl/core/clle_ctrl.sv -----
// Controller of the cursor linked list engine: sequences each command
// through walk, allocate, link update and result steps. Uses clle_pkg.
module clle_ctrl
    import clle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_WRD   = 4'd2;
    localparam logic [3:0] S_WCHK  = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_ARD   = 4'd5;
    localparam logic [3:0] S_ALLOC = 4'd6;
    localparam logic [3:0] S_W1    = 4'd7;
    localparam logic [3:0] S_W2    = 4'd8;
    localparam logic [3:0] S_SETA  = 4'd9;
    localparam logic [3:0] S_GIVE  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_HEAD  = 4'd12;

    logic [3:0] r_state, n_state;
    logic       walk_on;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        walk_on = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.kind)
                    KIND_INS_HEAD: n_state = S_DEC;
                    KIND_INS_TAIL, KIND_INS_SORT, KIND_DEL_VAL: n_state = S_WRD;
                    KIND_DEL_HEAD, KIND_DEL_TAIL: begin
                        if (i_stat.cur_node) begin
                            n_state = S_WRD;
                        end else begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_ABSENT;
                            n_state       = S_FIN;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_WRD: begin
                if (!i_stat.cur_node || i_stat.steps_done) begin
                    n_state = S_DEC;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = S_WCHK;
                end
            end
            S_WCHK: begin
                case (i_stat.kind)
                    KIND_INS_TAIL: walk_on = 1'b1;
                    KIND_INS_SORT: walk_on = i_stat.val_gt;
                    KIND_DEL_VAL:  walk_on = !i_stat.val_eq;
                    KIND_DEL_TAIL: walk_on = i_stat.link_node;
                    default:       walk_on = 1'b0;
                endcase
                if (walk_on) begin
                    o_cmd.advance = 1'b1;
                    if (i_stat.link_node && !i_stat.steps_last) begin
                        o_cmd.rd_link = 1'b1;
                    end else begin
                        n_state = S_DEC;
                    end
                end else begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                case (i_stat.kind)
                    KIND_INS_HEAD, KIND_INS_TAIL: begin
                        if (i_stat.free_node) begin
                            n_state = S_ARD;
                        end else begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_FULL;
                            n_state       = S_FIN;
                        end
                    end
                    KIND_INS_SORT: begin
                        if (i_stat.cur_node && i_stat.val_eq) begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_DUP;
                            n_state       = S_FIN;
                        end else if (i_stat.free_node) begin
                            n_state = S_ARD;
                        end else begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_FULL;
                            n_state       = S_FIN;
                        end
                    end
                    KIND_DEL_HEAD, KIND_DEL_TAIL: n_state = S_SETA;
                    KIND_DEL_VAL: begin
                        if (!i_stat.cur_node || !i_stat.val_eq) begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_ABSENT;
                            n_state       = S_FIN;
                        end else begin
                            n_state = S_SETA;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_ARD: begin
                o_cmd.rd_free = 1'b1;
                n_state       = S_ALLOC;
            end
            S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state     = S_W1;
            end
            S_W1: begin
                o_cmd.ins_w1 = 1'b1;
                n_state      = (i_stat.kind == KIND_INS_HEAD) ? S_FIN : S_W2;
            end
            S_W2: begin
                o_cmd.ins_w2 = 1'b1;
                n_state      = S_FIN;
            end
            S_SETA: begin
                o_cmd.set_after = 1'b1;
                n_state         = S_GIVE;
            end
            S_GIVE: begin
                o_cmd.give = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_HEAD;
            end
            S_HEAD: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/cursor_linked_list_engine.sv -----
// Cursor linked list engine: one signed list in a 32-node store with a free
// list. An unused kind or a head or tail delete on an empty list goes
// straight to the result; a head insert allocates and links without a walk,
// and a head delete reads the head node only. Tail insert, sorted insert, tail
// delete and value delete read one node per cycle along the links.
// One command is in work at a time. The next is taken once the result has
// entered the output register, and a result still held there stalls the
// following command at its last step.
// Top level; uses clle_pkg, clle_ctrl and clle_dp.
module cursor_linked_list_engine
    import clle_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [KIND_W-1:0]       i_kind,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [STAT_W-1:0]       o_status,
    output logic [SLOT_W-1:0]       o_slot,
    output logic [LEN_W-1:0]        o_length,
    output logic signed [VAL_W-1:0] o_head_value,
    output logic                    o_is_empty
);

    t_cmd  cmd;
    t_stat stat;

    clle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    clle_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_length     (o_length),
        .o_head_value (o_head_value),
        .o_is_empty   (o_is_empty)
    );

endmodule
